// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lfr_pkg.sv -----
// Shared widths, codes and controller/datapath interface types.
`default_nettype none

package lfr_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int WIDTH_W     = 32;
    localparam int RADIUS_W    = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = RADIUS_W;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6554;

    localparam int S_TDATA_W = VALUE_WIDTH + WIDTH_W;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 2 * VALUE_WIDTH;

    // differences and the shared multiplier
    localparam int DIFF_W = VALUE_WIDTH + 1;
    localparam int MUL_W  = DIFF_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int RDX_W  = RADIUS_W + WIDTH_W;
    localparam int S_W    = PROD_W;
    localparam int T_W    = 2 * RDX_W;

    // limiter terms in sixths of a difference, and the divide-by-three lanes
    localparam int LIM_W      = 40;
    localparam int DIV_DIGITS = 8;
    localparam int LANES      = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RADIUS  = 1'b0,
        CFG_ENFORCE = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        MUL_RDX  = 3'd0,
        MUL_AP   = 3'd1,
        MUL_AM   = 3'd2,
        MUL_TLO  = 3'd3,
        MUL_TMID = 3'd4,
        MUL_THI  = 3'd5
    } mul_op_t;

    typedef enum logic [2:0] {
        ACC_NONE  = 3'd0,
        ACC_RDX   = 3'd1,
        ACC_S_SET = 3'd2,
        ACC_S_ADD = 3'd3,
        ACC_T_SET = 3'd4,
        ACC_T_MID = 3'd5,
        ACC_T_HI  = 3'd6
    } acc_op_t;

    typedef struct packed {
        logic    take;
        mul_op_t mul_op;
        acc_op_t acc_op;
        logic    lim_load;
        logic    lane_load;
        logic    div_step;
        logic    cmp_load;
        logic    out_load;
    } lfr_cmd_t;

    typedef struct packed {
        logic emit_due;
    } lfr_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lfr_ctrl.sv -----
// Sequencer for the face reconstruction: handshakes and per-step commands.
`default_nettype none

module lfr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  lfr_pkg::lfr_status_t status,
    output lfr_pkg::lfr_cmd_t    cmd
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_RDX  = 10'b0000000010,
        ST_AP   = 10'b0000000100,
        ST_AM   = 10'b0000001000,
        ST_TLO  = 10'b0000010000,
        ST_TMID = 10'b0000100000,
        ST_THI  = 10'b0001000000,
        ST_TACC = 10'b0010000000,
        ST_CMP  = 10'b0100000000,
        ST_FACE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = lfr_pkg::MUL_AP;
        cmd.acc_op = lfr_pkg::ACC_NONE;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = s_tvalid;
                if (s_tvalid && status.emit_due)
                begin
                    state_next = ST_RDX;
                end
            end
            ST_RDX:
            begin
                cmd.mul_op   = lfr_pkg::MUL_RDX;
                cmd.lim_load = 1'b1;
                state_next   = ST_AP;
            end
            ST_AP:
            begin
                cmd.mul_op    = lfr_pkg::MUL_AP;
                cmd.acc_op    = lfr_pkg::ACC_RDX;
                cmd.lane_load = 1'b1;
                state_next    = ST_AM;
            end
            ST_AM:
            begin
                cmd.mul_op   = lfr_pkg::MUL_AM;
                cmd.acc_op   = lfr_pkg::ACC_S_SET;
                cmd.div_step = 1'b1;
                state_next   = ST_TLO;
            end
            ST_TLO:
            begin
                cmd.mul_op   = lfr_pkg::MUL_TLO;
                cmd.acc_op   = lfr_pkg::ACC_S_ADD;
                cmd.div_step = 1'b1;
                state_next   = ST_TMID;
            end
            ST_TMID:
            begin
                cmd.mul_op   = lfr_pkg::MUL_TMID;
                cmd.acc_op   = lfr_pkg::ACC_T_SET;
                cmd.div_step = 1'b1;
                state_next   = ST_THI;
            end
            ST_THI:
            begin
                cmd.mul_op   = lfr_pkg::MUL_THI;
                cmd.acc_op   = lfr_pkg::ACC_T_MID;
                cmd.div_step = 1'b1;
                state_next   = ST_TACC;
            end
            ST_TACC:
            begin
                cmd.acc_op   = lfr_pkg::ACC_T_HI;
                cmd.div_step = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp_load = 1'b1;
                state_next   = ST_FACE;
            end
            ST_FACE:
            begin
                // hold here until the output register can take the beat
                cmd.out_load = slot_free;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lfr_dpath.sv -----
// Datapath: cell window, shared multiplier, limiter, divide lanes, face output.
`default_nettype none

module lfr_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [lfr_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [lfr_pkg::S_TUSER_W-1:0]       s_tuser,
    input  lfr_pkg::lfr_cmd_t                   cmd,
    output lfr_pkg::lfr_status_t                status,
    output logic [lfr_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tuser
);

    localparam int VW       = lfr_pkg::VALUE_WIDTH;
    localparam int DW       = lfr_pkg::DIFF_W;
    localparam int LW       = lfr_pkg::LIM_W;
    localparam int ND       = lfr_pkg::DIV_DIGITS;
    localparam int XL_W     = lfr_pkg::WIDTH_W;
    localparam int XH_W     = lfr_pkg::RDX_W - XL_W;
    localparam int SCALE_SH = 2 * lfr_pkg::RADIUS_W;
    localparam int CMP_W    = lfr_pkg::S_W + SCALE_SH;
    localparam int TUSER_FORCE = 0;
    localparam int TUSER_START = 1;
    // lanes: plus q, plus psi, plus average, minus q, minus psi, minus average
    localparam logic [lfr_pkg::LANES-1:0] LANE_DIV24 = 6'b100100;
    localparam logic [LW-1:0] BIAS6  = LW'(6);
    localparam logic [LW-1:0] BIAS12 = LW'(12);

    // configuration and window control
    logic [lfr_pkg::RADIUS_W-1:0] radius_reg;
    logic                         enforce_reg;
    logic [1:0]                   fill_reg, fill_next, fill_base;

    // window payload
    logic signed [VW-1:0]         older_reg, centre_reg;
    logic [lfr_pkg::WIDTH_W-1:0]  cwidth_reg;
    logic                         cforced_reg;

    // work registers of the cell being reconstructed
    logic signed [DW-1:0]         dp_reg, dm_reg;
    logic [VW-1:0]                cv_reg;
    logic [lfr_pkg::WIDTH_W-1:0]  cw_reg;
    logic                         forced_reg;
    logic signed [LW-1:0]         q6p_reg, psip_reg, q6m_reg, psim_reg;
    logic [VW-1:0]                h_reg;

    logic [lfr_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [lfr_pkg::RDX_W-1:0]    rdx_reg;
    logic [lfr_pkg::S_W-1:0]      s_acc_reg;
    logic [lfr_pkg::T_W-1:0]      t_acc_reg;
    logic                         lt_reg, eq_reg;

    logic [LW-1:0]                lane_num_reg [lfr_pkg::LANES];
    logic [1:0]                   lane_rem_reg [lfr_pkg::LANES];
    logic                         lane_neg_reg [lfr_pkg::LANES];

    logic [VW-1:0]                plus_out_reg, minus_out_reg;
    logic                         mm_out_reg;

    // input beat fields
    logic signed [VW-1:0]         nv;
    logic [lfr_pkg::WIDTH_W-1:0]  nw;
    logic                         nf, nstart;

    logic signed [DW-1:0]         dp_next, dm_next, mm;
    logic signed [LW-1:0]         dpe, dme;
    logic [DW-1:0]                ap, am, mm_mag;
    logic [DW:0]                  mm_half;
    logic [VW-1:0]                h_next;
    logic [lfr_pkg::MUL_W-1:0]    mul_a, mul_b;
    logic [XL_W-1:0]              xl;
    logic [XH_W-1:0]              xh;
    logic [CMP_W-1:0]             ss, tt;

    logic signed [LW-1:0]         lane_src  [lfr_pkg::LANES];
    logic [LW-1:0]                lane_init [lfr_pkg::LANES];
    logic [LW-1:0]                lane_mag, lane_biased;
    logic [VW-1:0]                lane_off  [lfr_pkg::LANES];

    logic [VW-1:0]                sel_p, sel_m, plus_n, minus_n;
    logic                         use_mm;

    // clipped psi of LimO3 in sixths, sign-symmetric in the primary difference x
    function automatic logic signed [LW-1:0] lim_psi(input logic signed [LW-1:0] x,
                                                     input logic signed [LW-1:0] y);
        logic signed [LW-1:0] ax, by, qa, c9, c12, n3, t;
        ax  = x[LW-1] ? -x : x;
        by  = x[LW-1] ? -y : y;
        qa  = (ax <<< 2) + (by <<< 1);
        c9  = (ax <<< 3) + ax;
        c12 = (by <<< 3) + (by <<< 2);
        n3  = -((by <<< 1) + by);
        t   = (c9 < c12) ? c9 : c12;
        if (qa < t)
        begin
            t = qa;
        end
        if (n3 > t)
        begin
            t = n3;
        end
        if (qa < t)
        begin
            t = qa;
        end
        if (t[LW-1])
        begin
            t = '0;
        end
        return x[LW-1] ? -t : t;
    endfunction

    // one group of quotient digits of a divide by three, most significant first
    function automatic logic [LW+1:0] div3_step(input logic [LW-1:0] num,
                                                input logic [1:0]    rem);
        logic [1:0]    r;
        logic [2:0]    t;
        logic [ND-1:0] qb;
        r  = rem;
        qb = '0;
        for (int i = 0; i < ND; i++)
        begin
            t = {r, num[LW-1-i]};
            if (t >= 3'd3)
            begin
                qb[ND-1-i] = 1'b1;
                r          = 2'(t - 3'd3);
            end
            else
            begin
                r = t[1:0];
            end
        end
        return {r, num[LW-ND-1:0], qb};
    endfunction

    assign nv     = s_tdata[VW-1:0];
    assign nw     = s_tdata[lfr_pkg::S_TDATA_W-1:VW];
    assign nf     = s_tuser[TUSER_FORCE];
    assign nstart = s_tuser[TUSER_START];

    // a row start empties the window before this cell goes in
    assign fill_base       = nstart ? 2'd0 : fill_reg;
    assign status.emit_due = (fill_base == 2'd2);
    assign fill_next       = (fill_base == 2'd2) ? 2'd2 : 2'(fill_base + 2'd1);

    assign dp_next = DW'(nv) - DW'(centre_reg);
    assign dm_next = DW'(centre_reg) - DW'(older_reg);

    assign dpe = LW'(dp_reg);
    assign dme = LW'(dm_reg);
    assign ap  = dp_reg[DW-1] ? DW'(-dp_reg) : DW'(dp_reg);
    assign am  = dm_reg[DW-1] ? DW'(-dm_reg) : DW'(dm_reg);

    // minmod slope, halved with rounding away from zero
    always_comb
    begin
        if (!dp_reg[DW-1] && dp_reg != '0 && !dm_reg[DW-1] && dm_reg != '0)
        begin
            mm = (dp_reg < dm_reg) ? dp_reg : dm_reg;
        end
        else if (dp_reg[DW-1] && dm_reg[DW-1])
        begin
            mm = (dp_reg > dm_reg) ? dp_reg : dm_reg;
        end
        else
        begin
            mm = '0;
        end
        mm_mag  = mm[DW-1] ? DW'(-mm) : DW'(mm);
        mm_half = ((DW+1)'(mm_mag) + (DW+1)'(1)) >> 1;
        h_next  = mm[DW-1] ? (VW'(0) - mm_half[VW-1:0]) : mm_half[VW-1:0];
    end

    // operand select for the shared multiplier
    assign xl = rdx_reg[XL_W-1:0];
    assign xh = rdx_reg[lfr_pkg::RDX_W-1:XL_W];

    always_comb
    begin
        case (cmd.mul_op)
            lfr_pkg::MUL_RDX:
            begin
                mul_a = lfr_pkg::MUL_W'(radius_reg);
                mul_b = lfr_pkg::MUL_W'(cw_reg);
            end
            lfr_pkg::MUL_AP:
            begin
                mul_a = ap;
                mul_b = ap;
            end
            lfr_pkg::MUL_AM:
            begin
                mul_a = am;
                mul_b = am;
            end
            lfr_pkg::MUL_TLO:
            begin
                mul_a = lfr_pkg::MUL_W'(xl);
                mul_b = lfr_pkg::MUL_W'(xl);
            end
            lfr_pkg::MUL_TMID:
            begin
                mul_a = lfr_pkg::MUL_W'(xh);
                mul_b = lfr_pkg::MUL_W'(xl);
            end
            lfr_pkg::MUL_THI:
            begin
                mul_a = lfr_pkg::MUL_W'(xh);
                mul_b = lfr_pkg::MUL_W'(xh);
            end
            default:
            begin
                mul_a = ap;
                mul_b = ap;
            end
        endcase
        prod_next = lfr_pkg::PROD_W'(mul_a) * lfr_pkg::PROD_W'(mul_b);
    end

    // difference energy is in value units squared; (r*dx)^2 carries SCALE_SH more bits
    assign ss = {s_acc_reg, SCALE_SH'(0)};
    assign tt = CMP_W'(t_acc_reg);

    // divide lanes: |n| rounded to nearest by 12 (or 24) as (|n|+bias)>>2 (or 3), then /3
    always_comb
    begin
        lane_mag    = '0;
        lane_biased = '0;
        lane_src[0] = q6p_reg;
        lane_src[1] = psip_reg;
        lane_src[2] = q6p_reg + psip_reg;
        lane_src[3] = q6m_reg;
        lane_src[4] = psim_reg;
        lane_src[5] = q6m_reg + psim_reg;
        for (int k = 0; k < lfr_pkg::LANES; k++)
        begin
            lane_mag = lane_src[k][LW-1] ? LW'(-lane_src[k]) : LW'(lane_src[k]);
            if (LANE_DIV24[k])
            begin
                lane_biased  = lane_mag + BIAS12;
                lane_init[k] = lane_biased >> 3;
            end
            else
            begin
                lane_biased  = lane_mag + BIAS6;
                lane_init[k] = lane_biased >> 2;
            end
            lane_off[k] = lane_neg_reg[k] ? (VW'(0) - lane_num_reg[k][VW-1:0])
                                          : lane_num_reg[k][VW-1:0];
        end
    end

    // face values, with minmod fallback for forced cells or, if positivity is enforced, negative faces
    always_comb
    begin
        if (lt_reg)
        begin
            sel_p = lane_off[0];
            sel_m = lane_off[3];
        end
        else if (eq_reg)
        begin
            sel_p = lane_off[2];
            sel_m = lane_off[5];
        end
        else
        begin
            sel_p = lane_off[1];
            sel_m = lane_off[4];
        end
        plus_n  = cv_reg + sel_p;
        minus_n = cv_reg - sel_m;
        use_mm  = forced_reg || (enforce_reg && (plus_n[VW-1] || minus_n[VW-1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= lfr_pkg::RADIUS_RESET;
            enforce_reg <= 1'b0;
            fill_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    lfr_pkg::CFG_RADIUS:  radius_reg  <= cfg_data;
                    lfr_pkg::CFG_ENFORCE: enforce_reg <= cfg_data[0];
                    default:              enforce_reg <= enforce_reg;
                endcase
            end
            if (cmd.take)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            if (status.emit_due)
            begin
                dp_reg     <= dp_next;
                dm_reg     <= dm_next;
                cv_reg     <= centre_reg;
                cw_reg     <= cwidth_reg;
                forced_reg <= cforced_reg;
            end
            older_reg   <= centre_reg;
            centre_reg  <= nv;
            cwidth_reg  <= nw;
            cforced_reg <= nf;
        end

        if (cmd.lim_load)
        begin
            q6p_reg  <= (dpe <<< 2) + (dme <<< 1);
            psip_reg <= lim_psi(dpe, dme);
            q6m_reg  <= (dme <<< 2) + (dpe <<< 1);
            psim_reg <= lim_psi(dme, dpe);
            h_reg    <= h_next;
        end

        prod_reg <= prod_next;
        case (cmd.acc_op)
            lfr_pkg::ACC_RDX:   rdx_reg   <= prod_reg[lfr_pkg::RDX_W-1:0];
            lfr_pkg::ACC_S_SET: s_acc_reg <= prod_reg;
            lfr_pkg::ACC_S_ADD: s_acc_reg <= s_acc_reg + prod_reg;
            lfr_pkg::ACC_T_SET: t_acc_reg <= lfr_pkg::T_W'(prod_reg);
            lfr_pkg::ACC_T_MID: t_acc_reg <= t_acc_reg
                                    + lfr_pkg::T_W'({prod_reg[lfr_pkg::RDX_W-1:0],
                                                     (XL_W+1)'(0)});
            lfr_pkg::ACC_T_HI:  t_acc_reg <= t_acc_reg
                                    + {prod_reg[lfr_pkg::T_W-2*XL_W-1:0], (2*XL_W)'(0)};
            default:            rdx_reg   <= rdx_reg;
        endcase

        for (int k = 0; k < lfr_pkg::LANES; k++)
        begin
            if (cmd.lane_load)
            begin
                lane_num_reg[k] <= lane_init[k];
                lane_rem_reg[k] <= 2'd0;
                lane_neg_reg[k] <= lane_src[k][LW-1];
            end
            else if (cmd.div_step)
            begin
                {lane_rem_reg[k], lane_num_reg[k]} <= div3_step(lane_num_reg[k],
                                                                lane_rem_reg[k]);
            end
        end

        if (cmd.cmp_load)
        begin
            lt_reg <= (ss < tt);
            eq_reg <= (ss == tt);
        end

        if (cmd.out_load)
        begin
            plus_out_reg  <= use_mm ? (cv_reg + h_reg) : plus_n;
            minus_out_reg <= use_mm ? (cv_reg - h_reg) : minus_n;
            mm_out_reg    <= use_mm;
        end
    end

    assign m_tdata = {minus_out_reg, plus_out_reg};
    assign m_tuser = mm_out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/limo3_face_reconstruction.sv -----
// Once the input beat that completes a three-cell window is taken, s_tready stays low
// until the result is in the output register; beats that yield none go in one per cycle.
// Results are paced by the single 33x33 multiplier, forming six products per cell in turn.
// A finished result waits in the output register while the next input beat is taken.
// Reset (rst_n low, asynchronous) empties the window, drops any pending result and
// sets radius_factor to 6554 and enforce_positivity to 0.
`default_nettype none

module limo3_face_reconstruction (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [lfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lfr_pkg::S_TDATA_W-1:0]   s_tdata,   // cell_value, cell_width
    input  logic [lfr_pkg::S_TUSER_W-1:0]   s_tuser,   // force_minmod, start_of_row
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lfr_pkg::M_TDATA_W-1:0]   m_tdata,   // plus_face_value, minus_face_value
    output logic                            m_tuser    // used_minmod
);

    lfr_pkg::lfr_cmd_t    cmd;
    lfr_pkg::lfr_status_t status;

    lfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lfr_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lfr_checker.sv -----
// Port-level checker for the face reconstruction block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lfr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [lfr_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lfr_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);

    `ASSERT_NEXT(a_out_valid_held, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `ASSERT_NEXT(a_out_data_held, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
    // a row's first cell never completes a window, so the input stays open
    `ASSERT_NEXT(a_row_start_open, clk, rst_n, s_tvalid && s_tready && s_tuser[1], s_tready, "row start beat started a reconstruction")
    // a new result only appears after the block has been busy with it
    `ASSERT_NOW(a_result_after_busy, clk, rst_n, $rose(m_tvalid), !$past(s_tready), "result appeared without a busy phase")

endmodule

bind limo3_face_reconstruction lfr_checker u_lfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
